// ===== src/tdp_pkg.sv =====
// ----------------------------------------------------------------------------
// tdp_pkg
// Shared constants and types for the trial-division prime test unit.
// ----------------------------------------------------------------------------
package tdp_pkg;

    localparam int VALUE_WIDTH = 16;
    // divisor must reach floor(sqrt(max)) + 1
    localparam int DIV_WIDTH   = (VALUE_WIDTH + 1) / 2 + 1;
    localparam int SQ_WIDTH    = 2 * DIV_WIDTH;
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

    typedef struct packed {
        logic done;
        logic zero;
    } t_rem_stat;

endpackage

// ===== src/trial_division_prime_test_unit.sv =====
// ----------------------------------------------------------------------------
// trial_division_prime_test_unit
// Primality test by trial division, divisors 2, 3, ... while d*d <= value.
// ----------------------------------------------------------------------------
//  channel  | signals                          | word
//  ---------+----------------------------------+----------------------------
//  in       | i_valid, o_stall, i_candidate    | value to test
//  out      | o_valid, i_stall, o_is_prime     | 1 if prime
//
//  Each divisor takes a check step, a start step, a bit-serial remainder
//  over the VALUE_WIDTH dividend bits and a done step. The input is stalled
//  from the taking of a word until its result moves to the output register,
//  so a prime word holds it through every divisor up to floor(sqrt(v)), plus any output stall.
//  One word is in work at a time; a new word is taken while a result waits
//  in the output register. Synchronous active-low reset clears control state only.
// ----------------------------------------------------------------------------
module trial_division_prime_test_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [tdp_pkg::VALUE_WIDTH-1:0] i_candidate,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_is_prime
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_DONE
    } t_state;

    t_state                          r_state;
    logic                            r_valid;
    logic                            r_prime;
    logic                            r_res;
    logic                            r_start;
    logic [tdp_pkg::VALUE_WIDTH-1:0] r_cand;
    logic [tdp_pkg::DIV_WIDTH-1:0]   r_d;
    logic [tdp_pkg::SQ_WIDTH-1:0]    r_sq;
    logic [tdp_pkg::SQ_WIDTH-1:0]    n_sq;
    tdp_pkg::t_rem_stat              w_stat;
    logic                            w_accept;
    logic                            w_out_free;

    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_valid || !i_stall;
    // (d+1)^2 = d^2 + 2d + 1
    assign n_sq       = r_sq + tdp_pkg::SQ_WIDTH'({r_d, 1'b1});

    tdp_rem_unit u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_dividend (r_cand),
        .i_divisor  (r_d),
        .o_stat     (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_start <= 1'b0;
        end else begin
            r_start <= (r_state == S_CHECK) && (r_sq <= tdp_pkg::SQ_WIDTH'(r_cand));
            if (r_valid && !i_stall && (r_state != S_DONE)) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cand <= i_candidate;
                        r_d    <= tdp_pkg::DIV_WIDTH'(2);
                        r_sq   <= tdp_pkg::SQ_WIDTH'(4);
                        if (i_candidate < tdp_pkg::VALUE_WIDTH'(2)) begin
                            r_res   <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    if (r_sq > tdp_pkg::SQ_WIDTH'(r_cand)) begin
                        r_res   <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_stat.done) begin
                        if (w_stat.zero) begin
                            r_res   <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            r_d     <= r_d + 1'b1;
                            r_sq    <= n_sq;
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_valid <= 1'b1;
                        r_prime <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid    = r_valid;
    assign o_is_prime = r_prime;

endmodule

// ===== src/tdp_rem_unit.sv =====
// ----------------------------------------------------------------------------
// tdp_rem_unit
// Bit-serial restoring remainder: one dividend bit per cycle, all VALUE_WIDTH
// bits per divisor. Reports completion and a zero-remainder flag.
// ----------------------------------------------------------------------------
module tdp_rem_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [tdp_pkg::VALUE_WIDTH-1:0]   i_dividend,
    input  logic [tdp_pkg::DIV_WIDTH-1:0]     i_divisor,
    output tdp_pkg::t_rem_stat                o_stat
);

    logic                            r_busy;
    logic                            r_done;
    logic [tdp_pkg::CNT_WIDTH-1:0]   r_cnt;
    logic [tdp_pkg::VALUE_WIDTH-1:0] r_shift;
    logic [tdp_pkg::DIV_WIDTH-1:0]   r_rem;
    logic [tdp_pkg::DIV_WIDTH:0]     w_trial;
    logic [tdp_pkg::DIV_WIDTH-1:0]   n_rem;

    assign w_trial = {r_rem, r_shift[tdp_pkg::VALUE_WIDTH-1]};

    always_comb begin
        if (w_trial >= {1'b0, i_divisor}) begin
            n_rem = tdp_pkg::DIV_WIDTH'(w_trial - {1'b0, i_divisor});
        end else begin
            n_rem = w_trial[tdp_pkg::DIV_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == tdp_pkg::CNT_WIDTH'(tdp_pkg::VALUE_WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_rem   <= '0;
        end else if (r_busy) begin
            r_shift <= {r_shift[tdp_pkg::VALUE_WIDTH-2:0], 1'b0};
            r_rem   <= n_rem;
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.zero = (r_rem == '0);

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for trial_division_prime_test_unit. Candidate words are sent over
// the input channel with random gaps while the output side stalls at random.
// Each accepted word is classified by a local trial-division predictor and
// every result word is checked in order against it. Directed edge values,
// square boundaries, a gap-free burst and a long randomized mix are run in turn.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          VALUE_WIDTH    = tdp_pkg::VALUE_WIDTH;
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          DRAIN_CYCLES   = 5000;
    localparam int          RANDOM_WORDS   = 107;
    localparam int unsigned MAX_VALUE      = 2**VALUE_WIDTH - 1;
    localparam int unsigned ROOT_CAP       = 2**(VALUE_WIDTH / 2) - 1;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_valid     = 1'b0;
    logic [VALUE_WIDTH-1:0] i_candidate = '0;
    logic                   i_stall     = 1'b0;
    logic                   o_stall;
    logic                   o_valid;
    logic                   o_is_prime;

    logic                   prime_flags_due[$];
    logic                   due_flag;
    int                     errors      = 0;
    int                     idle_cycles = 0;
    bit                     calm        = 1'b0;

    trial_division_prime_test_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_candidate (i_candidate),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_is_prime  (o_is_prime)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic primality_of(input logic [VALUE_WIDTH-1:0] value);
        int unsigned v;
        int unsigned d;
        v = value;
        if (v < 2) begin
            return 1'b0;
        end
        for (d = 2; d * d <= v; d++) begin
            if (v % d == 0) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (calm) begin
            return 0;
        end
        if (r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] random_candidate();
        int unsigned r;
        int unsigned a;
        int unsigned b;
        r = $urandom_range(99);
        a = $urandom_range(2, ROOT_CAP);
        b = $urandom_range(2, MAX_VALUE / a);
        if (r < 35) begin
            return VALUE_WIDTH'($urandom);
        end
        if (r < 60) begin
            return VALUE_WIDTH'($urandom_range(0, 1023));
        end
        if (r < 75) begin
            return VALUE_WIDTH'(MAX_VALUE - $urandom_range(0, 600));
        end
        if (r < 85) begin
            return VALUE_WIDTH'(a * a);
        end
        if (r < 95) begin
            return VALUE_WIDTH'(a * b);
        end
        return VALUE_WIDTH'($urandom & $urandom);
    endfunction

    task automatic send_word(input logic [VALUE_WIDTH-1:0] value);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_valid     <= 1'b0;
            i_candidate <= VALUE_WIDTH'($urandom);
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_candidate <= value;
        do @(posedge i_clk); while (o_stall);
        prime_flags_due.push_back(primality_of(value));
    endtask

    task automatic test_range_edges();
        send_word(VALUE_WIDTH'(0));
        send_word(VALUE_WIDTH'(1));
        send_word(VALUE_WIDTH'(2));
        send_word(VALUE_WIDTH'(3));
        send_word(VALUE_WIDTH'(4));
        send_word(VALUE_WIDTH'(MAX_VALUE));
        send_word(VALUE_WIDTH'(MAX_VALUE - 1));
        send_word({1'b1, {(VALUE_WIDTH-1){1'b0}}});
        send_word({(VALUE_WIDTH/2){2'b10}});
    endtask

    // squares of primes sit right on the d*d <= v limit; other squares, products and values near 2**8 and 2**16 follow
    task automatic test_square_boundaries();
        send_word(VALUE_WIDTH'(9));
        send_word(VALUE_WIDTH'(25));
        send_word(VALUE_WIDTH'(49));
        send_word(VALUE_WIDTH'(121));
        send_word(VALUE_WIDTH'(251 * 251));
        send_word(VALUE_WIDTH'(255 * 255));
        send_word(VALUE_WIDTH'(65521));
        send_word(VALUE_WIDTH'(65519));
        send_word(VALUE_WIDTH'(251));
        send_word(VALUE_WIDTH'(253));
        send_word(VALUE_WIDTH'(257));
        send_word(VALUE_WIDTH'(254 * 257));
    endtask

    task automatic test_back_to_back();
        calm = 1'b1;
        repeat (12) send_word(random_candidate());
        calm = 1'b0;
    endtask

    task automatic test_random_mix();
        repeat (RANDOM_WORDS) send_word(random_candidate());
    endtask

    // output-side backpressure
    initial begin
        forever begin
            repeat ($urandom_range(1, 8)) begin
                @(negedge i_clk);
                i_stall <= 1'b0;
            end
            repeat (pick_gap()) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (prime_flags_due.size() == 0) begin
                $error("unexpected word: is_prime actual %0d", o_is_prime);
                errors++;
            end else begin
                due_flag = prime_flags_due.pop_front();
                if (o_is_prime !== due_flag) begin
                    $error("is_prime mismatch: expected %0d, actual %0d", due_flag, o_is_prime);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_range_edges();
        test_square_boundaries();
        test_back_to_back();
        test_random_mix();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (prime_flags_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && prime_flags_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
